[rtl/run_queue_policy_scheduler_unit_macros.svh]
// Assertion macros for the run queue scheduler
`ifndef RUN_QUEUE_POLICY_SCHEDULER_UNIT_MACROS_SVH
`define RUN_QUEUE_POLICY_SCHEDULER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define RQPS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RQPS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/rqps_pkg.sv]
// Types and constants shared by the run queue scheduler modules
package rqps_pkg;

	localparam int THREAD_W = 4;
	localparam int BURST_W  = 16;
	localparam int LEN_W    = 16;
	localparam int VR_W     = 31;
	localparam int STATUS_W = 2;
	localparam int POLICY_W = 2;

	localparam logic OP_INSERT   = 1'b0;
	localparam logic OP_DISPATCH = 1'b1;

	localparam logic [STATUS_W-1:0] ST_INSERTED   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DISPATCHED = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd3;

	localparam logic [POLICY_W-1:0] POL_FCFS     = 2'd0;
	localparam logic [POLICY_W-1:0] POL_SJF      = 2'd1;
	localparam logic [POLICY_W-1:0] POL_PRIO     = 2'd2;
	localparam logic [POLICY_W-1:0] POL_VRUNTIME = 2'd3;

	localparam logic REG_POLICY = 1'b0;

	localparam logic [VR_W-1:0] VR_MAX = 31'h7FFF_FFFF;

	// floor(x/10) = (x * DIV10_MUL) >> DIV10_SHIFT, exact for x below 2^22
	localparam int FACTOR_W    = 6;
	localparam int PROD_W      = 22;
	localparam int MUL_W       = 23;
	localparam int QUO_W       = 19;
	localparam int DIV10_SHIFT = 26;
	localparam logic [MUL_W-1:0] DIV10_MUL = 23'd6710887;

	typedef struct packed {
		logic                operation;
		logic [THREAD_W-1:0] in_thread;
		logic [BURST_W-1:0]  in_burst_number;
		logic [LEN_W-1:0]    in_length;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [THREAD_W-1:0] out_thread;
		logic [BURST_W-1:0]  out_burst_number;
		logic [LEN_W-1:0]    out_length;
		logic [VR_W-1:0]     out_vruntime;
	} out_item_t;

	typedef struct packed {
		logic [THREAD_W-1:0] thread;
		logic [BURST_W-1:0]  burst;
		logic [LEN_W-1:0]    length;
	} ent_t;

	typedef struct packed {
		logic                en;
		logic                set_vr;
		logic [THREAD_W-1:0] thread;
		logic [VR_W-1:0]     vr;
	} thr_upd_t;

endpackage

[rtl/rqps_queue_ram.sv]
// Queue entry memory kept in age order, one write and one registered read port
module rqps_queue_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  rqps_pkg::ent_t      wdata,
	input  logic [AW-1:0]       raddr,
	output rqps_pkg::ent_t      rdata
);
	import rqps_pkg::*;

	ent_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/rqps_thread_tab.sv]
// Per-thread expected burst numbers and vruntimes with one read and one update port
module rqps_thread_tab #(
	parameter int MAX_THREADS = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [rqps_pkg::THREAD_W-1:0]     rd_thread,
	output logic                              rd_ok,
	output logic [rqps_pkg::BURST_W-1:0]      rd_nexp,
	output logic [rqps_pkg::VR_W-1:0]         rd_vr,
	input  rqps_pkg::thr_upd_t                upd
);
	import rqps_pkg::*;

	localparam int IW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
	localparam logic [THREAD_W-1:0] TMAX = THREAD_W'(MAX_THREADS);

	logic [BURST_W-1:0] nexp_q [MAX_THREADS];
	logic [VR_W-1:0]    vr_q   [MAX_THREADS];
	logic [IW-1:0]      ridx;
	logic [IW-1:0]      widx;
	logic               wr_ok;

	function automatic logic thr_ok(input logic [THREAD_W-1:0] t);
		return (t != '0) && (t <= TMAX);
	endfunction

	function automatic logic [IW-1:0] thr_idx(input logic [THREAD_W-1:0] t);
		logic [THREAD_W-1:0] z;
		z = t - THREAD_W'(1);
		return IW'(z);
	endfunction

	assign rd_ok   = thr_ok(rd_thread);
	assign ridx    = thr_idx(rd_thread);
	assign rd_nexp = rd_ok ? nexp_q[ridx] : '0;
	assign rd_vr   = rd_ok ? vr_q[ridx] : '0;

	assign wr_ok = upd.en && thr_ok(upd.thread);
	assign widx  = thr_idx(upd.thread);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_THREADS; i++) begin
				nexp_q[i] <= '0;
				vr_q[i]   <= '0;
			end
		end else if (wr_ok) begin
			nexp_q[widx] <= nexp_q[widx] + BURST_W'(1);
			if (upd.set_vr) begin
				vr_q[widx] <= upd.vr;
			end
		end
	end

endmodule

[rtl/rqps_vr_calc.sv]
// Three-stage vruntime update: length times weight, divide by ten, saturating add
module rqps_vr_calc (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rqps_pkg::THREAD_W-1:0] thread,
	input  logic [rqps_pkg::LEN_W-1:0]    length,
	input  logic [rqps_pkg::VR_W-1:0]     vr_old,
	output logic                          done,
	output logic [rqps_pkg::VR_W-1:0]     vr_new
);
	import rqps_pkg::*;

	localparam int MP_W  = PROD_W + MUL_W;
	localparam int SUM_W = VR_W + 1;

	logic                v_s1, v_s2, v_s3;
	logic [PROD_W-1:0]   prod_s1;
	logic [QUO_W-1:0]    quo_s2;
	logic [VR_W-1:0]     vr_s3;
	logic [FACTOR_W-1:0] factor;
	logic [MP_W-1:0]     mp;
	logic [SUM_W-1:0]    sum;

	assign factor = FACTOR_W'(7) + FACTOR_W'(3) * FACTOR_W'(thread);
	assign mp     = MP_W'(prod_s1) * MP_W'(DIV10_MUL);
	assign sum    = {1'b0, vr_old} + SUM_W'(quo_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(length) * PROD_W'(factor);
		quo_s2  <= mp[DIV10_SHIFT +: QUO_W];
		vr_s3   <= sum[VR_W] ? VR_MAX : sum[VR_W-1:0];
	end

	assign done   = v_s3;
	assign vr_new = vr_s3;

endmodule

[rtl/run_queue_policy_scheduler_unit.sv]
// Run queue scheduler top level: sequencer, policy scan, config port
// An insert returns its result as a strobe on done the next cycle, and
// start is taken again at once. A dispatch keeps busy high while the
// queue memory is scanned one entry per cycle through its single read
// port, then the entries behind the chosen one move down one per cycle,
// then a three-stage vruntime unit runs.
// A dispatch on an empty queue or an insert on a full one is answered like
// an insert, without raising busy.
// done is high for exactly one cycle per item and cannot be held off.
module run_queue_policy_scheduler_unit #(
	parameter int MAX_THREADS = 10,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  rqps_pkg::in_item_t   item,
	output logic                 done,
	output rqps_pkg::out_item_t  result,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import rqps_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SHIFT, S_CALC} state_t;

	state_t              state_q;
	logic [POLICY_W-1:0] policy_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       rd_q;
	logic                v_s1;
	logic [CW-1:0]       rank_s1;
	logic                found_q;
	logic [CW-1:0]       pick_q;
	logic [VR_W-1:0]     best_key_q;
	ent_t                best_ent_q;
	ent_t                last_ent_q;
	ent_t                sel_ent_q;
	logic                calc_start_q;
	logic                done_q;
	out_item_t           result_q;

	logic                acc;
	logic                cfg_wr;
	logic                issue;
	logic                scan_end;
	logic                shift_end;
	logic [CW-1:0]       pick_fin;
	logic [CW-1:0]       wr_rank;
	ent_t                rd_ent;
	ent_t                in_ent;
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	ent_t                ram_wdata;
	logic [THREAD_W-1:0] tab_thread;
	logic                tab_ok;
	logic [BURST_W-1:0]  tab_nexp;
	logic [VR_W-1:0]     tab_vr;
	logic                elig;
	logic [VR_W-1:0]     key;
	logic                take;
	logic                calc_done;
	logic [VR_W-1:0]     calc_vr;
	thr_upd_t            upd;

	assign busy   = (state_q != S_IDLE);
	assign acc    = start && !busy;
	assign done   = done_q;
	assign result = result_q;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_POLICY);
	assign prdata = (paddr[2] == REG_POLICY) ? {{(32 - POLICY_W){1'b0}}, policy_q} : '0;

	assign in_ent.thread = item.in_thread;
	assign in_ent.burst  = item.in_burst_number;
	assign in_ent.length = item.in_length;

	assign issue     = ((state_q == S_SCAN) || (state_q == S_SHIFT)) && (rd_q != count_q);
	assign scan_end  = (state_q == S_SCAN) && (rd_q == count_q) && !v_s1;
	assign shift_end = (state_q == S_SHIFT) && (rd_q == count_q) && !v_s1;
	assign pick_fin  = found_q ? pick_q : (count_q - CW'(1));
	assign wr_rank   = rank_s1 - CW'(1);

	assign ram_we    = (acc && (item.operation == OP_INSERT) && (count_q != DEPTH_C))
	                   || ((state_q == S_SHIFT) && v_s1);
	assign ram_waddr = (state_q == S_SHIFT) ? wr_rank[AW-1:0] : count_q[AW-1:0];
	assign ram_wdata = (state_q == S_SHIFT) ? rd_ent : in_ent;

	rqps_queue_ram #(
		.DEPTH (QUEUE_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_q[AW-1:0]),
		.rdata (rd_ent)
	);

	assign tab_thread = (state_q == S_CALC) ? sel_ent_q.thread : rd_ent.thread;

	rqps_thread_tab #(
		.MAX_THREADS (MAX_THREADS)
	) u_tab (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_thread (tab_thread),
		.rd_ok     (tab_ok),
		.rd_nexp   (tab_nexp),
		.rd_vr     (tab_vr),
		.upd       (upd)
	);

	rqps_vr_calc u_calc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (calc_start_q),
		.thread (sel_ent_q.thread),
		.length (sel_ent_q.length),
		.vr_old (tab_vr),
		.done   (calc_done),
		.vr_new (calc_vr)
	);

	assign elig = tab_ok && (rd_ent.burst == tab_nexp);

	always_comb begin
		case (policy_q)
			POL_SJF:  key = VR_W'(rd_ent.length);
			POL_PRIO: key = VR_W'(rd_ent.thread);
			default:  key = tab_vr;
		endcase
	end

	assign take = (state_q == S_SCAN) && v_s1 && elig
	              && (!found_q || ((policy_q != POL_FCFS) && (key <= best_key_q)));

	assign upd.en     = (state_q == S_CALC) && calc_done;
	assign upd.set_vr = (policy_q == POL_VRUNTIME);
	assign upd.thread = sel_ent_q.thread;
	assign upd.vr     = calc_vr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			policy_q     <= POL_FCFS;
			count_q      <= '0;
			rd_q         <= '0;
			v_s1         <= 1'b0;
			rank_s1      <= '0;
			found_q      <= 1'b0;
			pick_q       <= '0;
			best_key_q   <= '0;
			best_ent_q   <= '0;
			last_ent_q   <= '0;
			sel_ent_q    <= '0;
			calc_start_q <= 1'b0;
			done_q       <= 1'b0;
			result_q     <= '0;
		end else begin
			done_q       <= 1'b0;
			calc_start_q <= 1'b0;
			v_s1         <= issue;
			rank_s1      <= rd_q;
			if (cfg_wr) begin
				policy_q <= pwdata[POLICY_W-1:0];
			end
			if (issue) begin
				rd_q <= rd_q + CW'(1);
			end
			if (take) begin
				found_q    <= 1'b1;
				pick_q     <= rank_s1;
				best_key_q <= key;
				best_ent_q <= rd_ent;
			end
			if ((state_q == S_SCAN) && v_s1) begin
				last_ent_q <= rd_ent;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						result_q <= '0;
						if (item.operation == OP_INSERT) begin
							done_q <= 1'b1;
							if (count_q == DEPTH_C) begin
								result_q.status <= ST_FULL;
							end else begin
								result_q.status <= ST_INSERTED;
								count_q         <= count_q + CW'(1);
							end
						end else if (count_q == '0) begin
							done_q          <= 1'b1;
							result_q.status <= ST_EMPTY;
						end else begin
							rd_q    <= '0;
							found_q <= 1'b0;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (scan_end) begin
						sel_ent_q <= found_q ? best_ent_q : last_ent_q;
						rd_q      <= pick_fin + CW'(1);
						state_q   <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (shift_end) begin
						count_q      <= count_q - CW'(1);
						calc_start_q <= 1'b1;
						state_q      <= S_CALC;
					end
				end
				S_CALC: begin
					if (calc_done) begin
						done_q                    <= 1'b1;
						result_q.status           <= ST_DISPATCHED;
						result_q.out_thread       <= sel_ent_q.thread;
						result_q.out_burst_number <= sel_ent_q.burst;
						result_q.out_length       <= sel_ent_q.length;
						if (!tab_ok) begin
							result_q.out_vruntime <= '0;
						end else if (policy_q == POL_VRUNTIME) begin
							result_q.out_vruntime <= calc_vr;
						end else begin
							result_q.out_vruntime <= tab_vr;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`include "run_queue_policy_scheduler_unit_macros.svh"

	`RQPS_ASSERT_IMP(a_count_bound, 1'b1, count_q <= DEPTH_C, "entry count above depth")
	`RQPS_ASSERT_NXT(a_insert_done, acc && item.operation == OP_INSERT && count_q != DEPTH_C, done && result.status == ST_INSERTED && count_q == $past(count_q) + CW'(1), "insert not stored")
	`RQPS_ASSERT_NXT(a_dispatch_busy, acc && item.operation == OP_DISPATCH && count_q != '0, busy && !done, "dispatch did not start scan")
	`RQPS_ASSERT_IMP(a_shift_addr, state_q == S_SHIFT && v_s1, rank_s1 != '0 && rank_s1 < count_q, "compaction write out of range")

endmodule

[verif/tb.sv]
// Self-checking testbench for the run queue scheduler: directed table and random phases
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rqps_pkg::*;

	localparam int NTHR = 10;
	localparam int QDEPTH = 16;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_ITEMS = 180;
	localparam int TAIL_CYCLES = 40;
	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic                cfg;
		logic [POLICY_W-1:0] pol;
		logic                fixed;
		in_item_t            it;
		out_item_t           want;
	} plan_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	in_item_t    item;
	logic        done;
	out_item_t   result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	logic [POLICY_W-1:0] pol_now;
	ent_t                slots [QDEPTH];
	int                  age [QDEPTH];
	int                  held;
	logic [BURST_W-1:0]  next_burst [1:NTHR];
	logic [VR_W-1:0]     vrun [1:NTHR];

	out_item_t pending_results [$];
	plan_row_t plan [$];
	out_item_t want;
	int        faults;
	longint    cycles;
	int        n_inserted, n_dropped, n_dispatched, n_empty, n_saturated;

	run_queue_policy_scheduler_unit #(
		.MAX_THREADS(NTHR),
		.QUEUE_DEPTH(QDEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic out_item_t predict_schedule(in_item_t it);
		out_item_t r;
		ent_t e;
		int pick, slot;
		logic found;
		logic [31:0] best, k, inc, v;
		r = '0;
		if (it.operation == OP_INSERT) begin
			if (held >= QDEPTH) begin
				r.status = ST_FULL;
			end else begin
				slots[age[held]] = '{thread: it.in_thread, burst: it.in_burst_number,
					length: it.in_length};
				held++;
				r.status = ST_INSERTED;
			end
			return r;
		end
		if (held == 0) begin
			r.status = ST_EMPTY;
			return r;
		end
		pick = held - 1;
		found = 1'b0;
		best = '0;
		for (int i = 0; i < held; i++) begin
			e = slots[age[i]];
			if (e.thread >= 1 && e.thread <= NTHR && e.burst == next_burst[e.thread]) begin
				if (pol_now == POL_FCFS) begin
					if (!found) begin
						pick = i;
						found = 1'b1;
					end
				end else begin
					if (pol_now == POL_SJF) k = 32'(e.length);
					else if (pol_now == POL_PRIO) k = 32'(e.thread);
					else k = 32'(vrun[e.thread]);
					if (!found || k <= best) begin
						pick = i;
						best = k;
						found = 1'b1;
					end
				end
			end
		end
		slot = age[pick];
		e = slots[slot];
		for (int i = pick; i + 1 < held; i++) age[i] = age[i + 1];
		held--;
		age[held] = slot;
		r.status = ST_DISPATCHED;
		r.out_thread = e.thread;
		r.out_burst_number = e.burst;
		r.out_length = e.length;
		if (e.thread >= 1 && e.thread <= NTHR) begin
			next_burst[e.thread] = next_burst[e.thread] + 1'b1;
			if (pol_now == POL_VRUNTIME) begin
				inc = (32'(e.length) * (32'd7 + 32'd3 * 32'(e.thread))) / 32'd10;
				v = 32'(vrun[e.thread]);
				vrun[e.thread] = (inc > 32'(VR_MAX) - v) ? VR_MAX : VR_W'(v + inc);
			end
			r.out_vruntime = vrun[e.thread];
		end
		return r;
	endfunction

	function automatic in_item_t gen_item(int ins_pct);
		in_item_t x;
		int pick;
		x.operation = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_DISPATCH;
		x.in_thread = 4'($urandom);
		x.in_burst_number = 16'($urandom);
		x.in_length = 16'($urandom);
		if (x.operation == OP_DISPATCH) return x;
		pick = $urandom_range(99);
		if (pick < 5) x.in_thread = 4'd0;
		else if (pick < 10) x.in_thread = 4'($urandom_range(NTHR + 1, 15));
		else x.in_thread = 4'($urandom_range(1, NTHR));
		pick = $urandom_range(99);
		if (x.in_thread >= 1 && x.in_thread <= NTHR) begin
			if (pick < 75) x.in_burst_number = next_burst[x.in_thread];
			else if (pick < 90)
				x.in_burst_number = next_burst[x.in_thread] + 16'($urandom_range(1, 3));
		end
		pick = $urandom_range(99);
		if (pick < 40) x.in_length = 16'($urandom_range(15));
		else if (pick < 48) x.in_length = '0;
		else if (pick < 56) x.in_length = '1;
		return x;
	endfunction

	function automatic plan_row_t op_row(logic op, logic [THREAD_W-1:0] t,
		logic [BURST_W-1:0] b, logic [LEN_W-1:0] l, logic fixed, logic [STATUS_W-1:0] st);
		plan_row_t r;
		r = '0;
		r.it.operation = op;
		r.it.in_thread = t;
		r.it.in_burst_number = b;
		r.it.in_length = l;
		r.fixed = fixed;
		r.want.status = st;
		return r;
	endfunction

	function automatic plan_row_t pol_row(logic [POLICY_W-1:0] p);
		plan_row_t r;
		r = '0;
		r.cfg = 1'b1;
		r.pol = p;
		return r;
	endfunction

	function automatic void note_fault(string msg);
		faults++;
		if (faults <= 10) $display("mismatch: %s", msg);
	endfunction

	task automatic send_item(in_item_t it, int gap, logic fixed, out_item_t typed);
		out_item_t pred;
		if (gap > 0) begin
			@(negedge clk) start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy !== 1'b0);
		pred = predict_schedule(it);
		pending_results.push_back(fixed ? typed : pred);
	endtask

	task automatic set_policy(logic [POLICY_W-1:0] p);
		@(negedge clk) start <= 1'b0;
		while (pending_results.size() != 0 || busy !== 1'b0) @(posedge clk);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_POLICY, 2'b00};
		pwdata <= 32'(p);
		@(negedge clk) penable <= 1'b1;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk) penable <= 1'b1;
		@(posedge clk);
		if (prdata !== 32'(p))
			note_fault($sformatf("policy readback expected %0d actual %0h", p, prdata));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pol_now = p;
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL run_queue_policy_scheduler_unit");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				note_fault($sformatf("result with nothing pending: %h", result));
			end else begin
				want = pending_results.pop_front();
				if (result.status !== want.status || result.out_thread !== want.out_thread ||
					result.out_burst_number !== want.out_burst_number ||
					result.out_length !== want.out_length ||
					result.out_vruntime !== want.out_vruntime)
					note_fault($sformatf({"status %0d/%0d thread %0d/%0d burst %h/%h ",
						"length %h/%h vruntime %h/%h (expected/actual)"},
						want.status, result.status, want.out_thread, result.out_thread,
						want.out_burst_number, result.out_burst_number,
						want.out_length, result.out_length,
						want.out_vruntime, result.out_vruntime));
			end
			case (result.status)
				ST_INSERTED: n_inserted++;
				ST_FULL: n_dropped++;
				ST_DISPATCHED: n_dispatched++;
				default: n_empty++;
			endcase
			if (result.out_vruntime === VR_MAX) n_saturated++;
		end
	end

	initial begin
		int gap;
		logic [POLICY_W-1:0] p;

		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		faults = 0;
		cycles = 0;
		pol_now = POL_FCFS;
		held = 0;
		for (int i = 0; i < QDEPTH; i++) age[i] = i;
		for (int t = 1; t <= NTHR; t++) begin
			next_burst[t] = '0;
			vrun[t] = '0;
		end

		plan.push_back(op_row(OP_DISPATCH, 4'hF, 16'hFFFF, 16'hFFFF, 1'b1, ST_EMPTY));
		plan.push_back(op_row(OP_INSERT, 4'd1, 16'd0, 16'hFFFF, 1'b1, ST_INSERTED));
		plan.push_back(op_row(OP_INSERT, 4'd0, 16'd0, 16'd5, 1'b1, ST_INSERTED));
		plan.push_back(op_row(OP_INSERT, 4'd15, 16'hFFFF, 16'd0, 1'b1, ST_INSERTED));
		plan.push_back(op_row(OP_INSERT, 4'd10, 16'd0, 16'd0, 1'b1, ST_INSERTED));
		plan.push_back(op_row(OP_INSERT, 4'd2, 16'd1, 16'd3, 1'b1, ST_INSERTED));
		plan.push_back(op_row(OP_DISPATCH, 4'd0, 16'd0, 16'd0, 1'b0, ST_DISPATCHED));
		plan.push_back(op_row(OP_DISPATCH, 4'hF, 16'hFFFF, 16'hFFFF, 1'b0, ST_DISPATCHED));
		plan.push_back(op_row(OP_DISPATCH, 4'd0, 16'd0, 16'd0, 1'b0, ST_DISPATCHED));
		plan.push_back(op_row(OP_DISPATCH, 4'd0, 16'd0, 16'd0, 1'b0, ST_DISPATCHED));
		plan.push_back(op_row(OP_DISPATCH, 4'd0, 16'd0, 16'd0, 1'b0, ST_DISPATCHED));
		plan.push_back(op_row(OP_DISPATCH, 4'd0, 16'd0, 16'd0, 1'b1, ST_EMPTY));
		plan.push_back(pol_row(POL_SJF));
		plan.push_back(op_row(OP_INSERT, 4'd3, 16'd0, 16'd7, 1'b1, ST_INSERTED));
		plan.push_back(op_row(OP_INSERT, 4'd4, 16'd0, 16'd7, 1'b1, ST_INSERTED));
		plan.push_back(op_row(OP_INSERT, 4'd5, 16'd0, 16'd9, 1'b1, ST_INSERTED));
		plan.push_back(op_row(OP_DISPATCH, 4'd0, 16'd0, 16'd0, 1'b0, ST_DISPATCHED));
		plan.push_back(pol_row(POL_PRIO));
		plan.push_back(op_row(OP_DISPATCH, 4'd0, 16'd0, 16'd0, 1'b0, ST_DISPATCHED));
		plan.push_back(pol_row(POL_VRUNTIME));
		plan.push_back(op_row(OP_INSERT, 4'd10, 16'd1, 16'hFFFF, 1'b1, ST_INSERTED));
		plan.push_back(op_row(OP_DISPATCH, 4'd0, 16'd0, 16'd0, 1'b0, ST_DISPATCHED));
		plan.push_back(op_row(OP_DISPATCH, 4'd0, 16'd0, 16'd0, 1'b0, ST_DISPATCHED));
		plan.push_back(op_row(OP_DISPATCH, 4'd0, 16'd0, 16'd0, 1'b1, ST_EMPTY));

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].cfg) set_policy(plan[i].pol);
			else send_item(plan[i].it, 0, plan[i].fixed, plan[i].want);
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph % 4)
				0: p = POL_SJF;
				1: p = POL_PRIO;
				2: p = POL_FCFS;
				default: p = POL_VRUNTIME;
			endcase
			set_policy(p);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				gap = (ph < RAND_PHASES - 2 && $urandom_range(4) == 0) ? $urandom_range(1, 15) : 0;
				send_item(gen_item((ph % 2) ? 60 : 40), gap, 1'b0, '0);
			end
		end

		@(negedge clk) start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Results seen: %0d inserted, %0d dropped on full, %0d dispatched, %0d empty",
			n_inserted, n_dropped, n_dispatched, n_empty);
		$display("All four policies run with input gaps; %0d dispatches at vruntime limit",
			n_saturated);
		if (faults == 0) begin
			$display("PASS run_queue_policy_scheduler_unit");
		end else begin
			$display("FAIL run_queue_policy_scheduler_unit");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl
rtl/rqps_pkg.sv
rtl/rqps_queue_ram.sv
rtl/rqps_thread_tab.sv
rtl/rqps_vr_calc.sv
rtl/run_queue_policy_scheduler_unit.sv
verif/tb.sv
